[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check.
`define PTRF_ASSERT_SAME(name, clk, rst_n, cond, chk) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (chk)) \
        else $error("ptrf same-cycle check failed");

// Next-cycle implication check.
`define PTRF_ASSERT_NEXT(name, clk, rst_n, cond, chk) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (chk)) \
        else $error("ptrf next-cycle check failed");

`endif

[src/ptrf_pkg.sv]
package ptrf_pkg;

    localparam int W_OP        = 2;
    localparam int W_POS       = 7;
    localparam int W_COUNT     = 16;
    localparam int W_WORD      = 32;
    localparam int W_HALF      = 16;
    localparam int W_PIN_SEL   = 3;
    localparam int W_CFG_INDEX = 2;
    localparam int W_CFG_DATA  = 16;

    localparam int PIN_COUNT   = 8;
    localparam int PIN_BIT_W   = 4;
    localparam int RESYNC_LEAD = 10;
    // conditional subtract steps for small modulo reductions
    localparam int MOD_STEPS   = 8;

    localparam logic [W_OP-1:0] OP_REFILL = 2'd0;
    localparam logic [W_OP-1:0] OP_INIT   = 2'd1;
    localparam logic [W_OP-1:0] OP_REMOVE = 2'd2;
    localparam logic [W_OP-1:0] OP_READ   = 2'd3;

    localparam logic [W_CFG_INDEX-1:0] CFG_PIN_SELECT  = 2'd0;
    localparam logic [W_CFG_INDEX-1:0] CFG_HIGH_RELOAD = 2'd1;
    localparam logic [W_CFG_INDEX-1:0] CFG_LOW_RELOAD  = 2'd2;

    typedef enum logic [1:0] {
        SRC_RING = 2'd0,
        SRC_HIGH = 2'd1,
        SRC_LOW  = 2'd2
    } t_run_src;

    typedef struct packed {
        logic     load;
        logic     sweep_clear;
        logic     sweep_fill;
        logic     read;
        logic     rmv_calc;
        logic     rmv_apply;
        logic     run_start;
        t_run_src run_src;
        logic     run_level;
        logic     run_step;
        logic     high_end;
        logic     low_end;
        logic     emit;
    } t_dp_cmd;

    typedef struct packed {
        logic sweep_last;
        logic run_done;
        logic run_cnt_zero;
        logic high_left_zero;
        logic high_reload_zero;
        logic low_reload_zero;
    } t_dp_sts;

endpackage

[src/ptrf_in_if.sv]
interface ptrf_in_if;
    logic                          valid;
    logic                          ready;
    logic [ptrf_pkg::W_OP-1:0]     operation;
    logic [ptrf_pkg::W_POS-1:0]    reader_position;
    logic                          fill_level;
    logic [ptrf_pkg::W_COUNT-1:0]  remove_count;
    logic [ptrf_pkg::W_POS-1:0]    keep_margin;
    logic [ptrf_pkg::W_POS-1:0]    entry_index;

    modport source (
        output valid, operation, reader_position, fill_level, remove_count,
               keep_margin, entry_index,
        input  ready
    );

    modport sink (
        input  valid, operation, reader_position, fill_level, remove_count,
               keep_margin, entry_index,
        output ready
    );
endinterface

[src/ptrf_out_if.sv]
interface ptrf_out_if;
    logic                         valid;
    logic                         ready;
    logic [ptrf_pkg::W_POS-1:0]   removed_entries;
    logic [ptrf_pkg::W_WORD-1:0]  entry_word;
    logic [ptrf_pkg::W_POS-1:0]   write_position;

    modport source (
        output valid, removed_entries, entry_word, write_position,
        input  ready
    );

    modport sink (
        input  valid, removed_entries, entry_word, write_position,
        output ready
    );
endinterface

[src/ptrf_ctrl.sv]
module ptrf_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [ptrf_pkg::W_OP-1:0]  i_in_op,
    output logic                       o_in_ready,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    input  ptrf_pkg::t_dp_sts          i_sts,
    output ptrf_pkg::t_dp_cmd          o_cmd
);

    typedef enum logic [12:0] {
        S_CLEAR  = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_INIT   = 13'b0000000000100,
        S_RD     = 13'b0000000001000,
        S_RMV1   = 13'b0000000010000,
        S_RMV2   = 13'b0000000100000,
        S_RSTART = 13'b0000001000000,
        S_RHIGH  = 13'b0000010000000,
        S_RLOW   = 13'b0000100000000,
        S_RWRITE = 13'b0001000000000,
        S_RHEND  = 13'b0010000000000,
        S_RLEND  = 13'b0100000000000,
        S_EMIT   = 13'b1000000000000
    } t_state;

    typedef enum logic [1:0] {
        RK_CONST = 2'd0,
        RK_HIGH  = 2'd1,
        RK_LOW   = 2'd2
    } t_run_kind;

    t_state    r_state, n_state;
    t_run_kind r_kind, n_kind;
    logic      r_out_valid, n_out_valid;

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.sweep_clear = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_in_op)
                        ptrf_pkg::OP_REFILL: n_state = S_RSTART;
                        ptrf_pkg::OP_INIT:   n_state = S_INIT;
                        ptrf_pkg::OP_REMOVE: n_state = S_RMV1;
                        ptrf_pkg::OP_READ:   n_state = S_RD;
                        default:             n_state = S_RD;
                    endcase
                end
            end
            S_INIT: begin
                o_cmd.sweep_fill = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_EMIT;
                end
            end
            S_RD: begin
                o_cmd.read = 1'b1;
                n_state    = S_EMIT;
            end
            S_RMV1: begin
                o_cmd.rmv_calc = 1'b1;
                n_state        = S_RMV2;
            end
            S_RMV2: begin
                o_cmd.rmv_apply = 1'b1;
                n_state         = S_EMIT;
            end
            S_RSTART: begin
                if (i_sts.high_reload_zero) begin
                    o_cmd.run_start = 1'b1;
                    o_cmd.run_src   = ptrf_pkg::SRC_RING;
                    o_cmd.run_level = 1'b0;
                    n_kind          = RK_CONST;
                    n_state         = S_RWRITE;
                end else if (i_sts.low_reload_zero) begin
                    o_cmd.run_start = 1'b1;
                    o_cmd.run_src   = ptrf_pkg::SRC_RING;
                    o_cmd.run_level = 1'b1;
                    n_kind          = RK_CONST;
                    n_state         = S_RWRITE;
                end else begin
                    n_state = S_RHIGH;
                end
            end
            S_RHIGH: begin
                if (!i_sts.high_left_zero) begin
                    o_cmd.run_start = 1'b1;
                    o_cmd.run_src   = ptrf_pkg::SRC_HIGH;
                    o_cmd.run_level = 1'b1;
                    n_kind          = RK_HIGH;
                    n_state         = S_RWRITE;
                end else begin
                    n_state = S_RLOW;
                end
            end
            S_RLOW: begin
                if (i_sts.high_left_zero) begin
                    o_cmd.run_start = 1'b1;
                    o_cmd.run_src   = ptrf_pkg::SRC_LOW;
                    o_cmd.run_level = 1'b0;
                    n_kind          = RK_LOW;
                    n_state         = S_RWRITE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_RWRITE: begin
                o_cmd.run_step = 1'b1;
                if (i_sts.run_done) begin
                    case (r_kind)
                        RK_HIGH: n_state = S_RHEND;
                        RK_LOW:  n_state = S_RLEND;
                        default: n_state = S_EMIT;
                    endcase
                end
            end
            S_RHEND: begin
                o_cmd.high_end = 1'b1;
                n_state        = S_RLOW;
            end
            S_RLEND: begin
                o_cmd.low_end = 1'b1;
                n_state       = i_sts.run_cnt_zero ? S_RHIGH : S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_kind      <= RK_CONST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[src/ptrf_dp.sv]
module ptrf_dp #(
    parameter int RING_DEPTH = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ptrf_pkg::t_dp_cmd                 i_cmd,
    output ptrf_pkg::t_dp_sts                 o_sts,
    input  logic [ptrf_pkg::W_OP-1:0]         i_operation,
    input  logic [ptrf_pkg::W_POS-1:0]        i_reader_position,
    input  logic                              i_fill_level,
    input  logic [ptrf_pkg::W_COUNT-1:0]      i_remove_count,
    input  logic [ptrf_pkg::W_POS-1:0]        i_keep_margin,
    input  logic [ptrf_pkg::W_POS-1:0]        i_entry_index,
    input  logic                              i_cfg_we,
    input  logic [ptrf_pkg::W_CFG_INDEX-1:0]  i_cfg_index,
    input  logic [ptrf_pkg::W_CFG_DATA-1:0]   i_cfg_data,
    output logic [ptrf_pkg::W_POS-1:0]        o_removed_entries,
    output logic [ptrf_pkg::W_WORD-1:0]       o_entry_word,
    output logic [ptrf_pkg::W_POS-1:0]        o_write_position
);

    localparam int PW  = $clog2(RING_DEPTH);
    localparam int PW1 = PW + 1;
    localparam int RW  = ((PW > ptrf_pkg::W_POS) ? PW : ptrf_pkg::W_POS) + 1;
    localparam int AW  = RW + 1;
    localparam int HW  = ptrf_pkg::W_HALF;
    localparam int WW  = ptrf_pkg::W_WORD;
    localparam int CW  = ptrf_pkg::W_COUNT;
    localparam int BW  = ptrf_pkg::PIN_BIT_W + 1;
    localparam logic [PW-1:0] LAST_ENTRY = PW'(RING_DEPTH - 1);

    function automatic logic [PW-1:0] ring_wrap(input logic [ptrf_pkg::W_POS-1:0] pos);
        logic [RW-1:0] v;
        v = RW'(pos);
        for (int k = 0; k < ptrf_pkg::MOD_STEPS; k++) begin
            if (v >= RW'(RING_DEPTH)) begin
                v = v - RW'(RING_DEPTH);
            end
        end
        return v[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] resync_pos(input logic [PW-1:0] pos);
        logic [PW1-1:0] s;
        s = PW1'(pos) + PW1'(ptrf_pkg::RESYNC_LEAD);
        if (s >= PW1'(RING_DEPTH)) begin
            s = s - PW1'(RING_DEPTH);
        end
        return s[PW-1:0];
    endfunction

    function automatic logic [ptrf_pkg::PIN_BIT_W-1:0] pin_bit(
        input logic [ptrf_pkg::W_PIN_SEL-1:0] sel
    );
        logic [BW-1:0] v;
        v = BW'(sel) + BW'(1);
        for (int k = 0; k < ptrf_pkg::MOD_STEPS; k++) begin
            if (v >= BW'(ptrf_pkg::PIN_COUNT)) begin
                v = v - BW'(ptrf_pkg::PIN_COUNT);
            end
        end
        return v[ptrf_pkg::PIN_BIT_W-1:0];
    endfunction

    // configuration
    logic [ptrf_pkg::W_PIN_SEL-1:0] r_pin_sel;
    logic [CW-1:0]                  r_high_reload;
    logic [CW-1:0]                  r_low_reload;

    // ring state
    logic [WW-1:0] r_ring [RING_DEPTH];
    logic [PW-1:0] r_wp;
    logic          r_resync;
    logic [CW-1:0] r_high_left;
    logic [CW-1:0] r_low_left;
    logic [PW-1:0] r_sweep;

    // item fields
    logic [ptrf_pkg::W_OP-1:0]  r_op;
    logic [PW-1:0]              r_rd_pos;
    logic                       r_fill_level;
    logic [CW-1:0]              r_rm_count;
    logic [ptrf_pkg::W_POS-1:0] r_margin;
    logic [PW-1:0]              r_idx;

    // work registers
    logic [CW-1:0]        r_run_cnt;
    logic                 r_run_level;
    logic signed [AW-1:0] r_avail;
    logic                 r_no_queue;
    logic [PW-1:0]        r_removed;
    logic [WW-1:0]        r_rd_word;

    logic [ptrf_pkg::W_POS-1:0] r_o_removed;
    logic [WW-1:0]              r_o_word;
    logic [ptrf_pkg::W_POS-1:0] r_o_wpos;

    logic [HW-1:0]        half_mask;
    logic [WW-1:0]        pin_mask;
    logic                 run_done;
    logic                 mem_we;
    logic [PW-1:0]        mem_addr;
    logic [WW-1:0]        mem_mask;
    logic [WW-1:0]        mem_data;
    logic [PW-1:0]        wp_inc;
    logic [PW1-1:0]       queue_len;
    logic signed [AW-1:0] avail_c;
    logic                 removable;
    logic [PW-1:0]        avail_u;
    logic [PW-1:0]        removed_c;
    logic [PW-1:0]        wp_back;
    logic [CW-1:0]        run_cnt_init;

    assign half_mask = HW'(1) << pin_bit(r_pin_sel);
    assign pin_mask  = {half_mask, half_mask};
    assign run_done  = (r_run_cnt == '0) || (r_wp == r_rd_pos);
    assign wp_inc    = (r_wp == LAST_ENTRY) ? '0 : r_wp + PW'(1);

    // low half sets the pin, high half clears it
    always_comb begin
        mem_we   = 1'b0;
        mem_addr = r_wp;
        mem_mask = pin_mask;
        mem_data = r_run_level ? {{HW{1'b0}}, half_mask} : {half_mask, {HW{1'b0}}};
        if (i_cmd.sweep_clear) begin
            mem_we   = 1'b1;
            mem_addr = r_sweep;
            mem_mask = '1;
            mem_data = '0;
        end else if (i_cmd.sweep_fill) begin
            mem_we   = 1'b1;
            mem_addr = r_sweep;
            mem_data = r_fill_level ? {{HW{1'b0}}, half_mask} : {half_mask, {HW{1'b0}}};
        end else if (i_cmd.run_step && !run_done) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            for (int b = 0; b < WW; b++) begin
                if (mem_mask[b]) begin
                    r_ring[mem_addr][b] <= mem_data[b];
                end
            end
        end
        if (i_cmd.read) begin
            r_rd_word <= r_ring[r_idx];
        end
    end

    // retract arithmetic
    always_comb begin
        if (r_wp >= r_rd_pos) begin
            queue_len = PW1'(r_wp) - PW1'(r_rd_pos);
        end else begin
            queue_len = PW1'(r_wp) + PW1'(RING_DEPTH) - PW1'(r_rd_pos);
        end
        avail_c   = $signed(AW'(queue_len)) - $signed(AW'(r_margin));
        removable = !r_no_queue && !r_avail[AW-1] && (r_avail != '0);
        avail_u   = r_avail[PW-1:0];
        if (!removable) begin
            removed_c = '0;
        end else if (CW'(avail_u) >= r_rm_count) begin
            removed_c = PW'(r_rm_count);
        end else begin
            removed_c = avail_u;
        end
        if (r_wp >= removed_c) begin
            wp_back = r_wp - removed_c;
        end else begin
            wp_back = PW'(PW1'(r_wp) + PW1'(RING_DEPTH) - PW1'(removed_c));
        end
    end

    always_comb begin
        case (i_cmd.run_src)
            ptrf_pkg::SRC_HIGH: run_cnt_init = r_high_left;
            ptrf_pkg::SRC_LOW:  run_cnt_init = r_low_left;
            default:            run_cnt_init = CW'(RING_DEPTH);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_sel     <= '0;
            r_high_reload <= '0;
            r_low_reload  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ptrf_pkg::CFG_PIN_SELECT:  r_pin_sel     <= i_cfg_data[ptrf_pkg::W_PIN_SEL-1:0];
                ptrf_pkg::CFG_HIGH_RELOAD: r_high_reload <= i_cfg_data;
                ptrf_pkg::CFG_LOW_RELOAD:  r_low_reload  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_resync    <= 1'b0;
            r_high_left <= '0;
            r_low_left  <= '0;
            r_sweep     <= '0;
        end else begin
            if (i_cmd.sweep_clear || i_cmd.sweep_fill) begin
                r_sweep <= (r_sweep == LAST_ENTRY) ? '0 : r_sweep + PW'(1);
            end
            if (i_cmd.sweep_fill && (r_sweep == LAST_ENTRY)) begin
                r_resync <= 1'b1;
            end
            if (i_cmd.run_start && r_resync) begin
                r_resync <= 1'b0;
                r_wp     <= resync_pos(r_rd_pos);
            end else if (i_cmd.run_step && !run_done) begin
                r_wp <= wp_inc;
            end else if (i_cmd.rmv_apply) begin
                r_wp <= wp_back;
            end
            if (i_cmd.high_end) begin
                r_high_left <= r_run_cnt;
                r_low_left  <= r_low_reload;
            end else if (i_cmd.low_end) begin
                if (r_run_cnt == '0) begin
                    r_high_left <= r_high_reload;
                    r_low_left  <= r_low_reload;
                end else begin
                    r_low_left <= r_run_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op         <= i_operation;
            r_rd_pos     <= ring_wrap(i_reader_position);
            r_fill_level <= i_fill_level;
            r_rm_count   <= i_remove_count;
            r_margin     <= i_keep_margin;
            r_idx        <= ring_wrap(i_entry_index);
        end
        if (i_cmd.run_start) begin
            r_run_cnt   <= run_cnt_init;
            r_run_level <= i_cmd.run_level;
        end else if (i_cmd.run_step && !run_done) begin
            r_run_cnt <= r_run_cnt - CW'(1);
        end
        if (i_cmd.rmv_calc) begin
            r_avail    <= avail_c;
            r_no_queue <= (r_wp == r_rd_pos);
        end
        if (i_cmd.rmv_apply) begin
            r_removed <= removed_c;
        end
        if (i_cmd.emit) begin
            r_o_removed <= (r_op == ptrf_pkg::OP_REMOVE) ? ptrf_pkg::W_POS'(r_removed) : '0;
            r_o_word    <= (r_op == ptrf_pkg::OP_READ) ? r_rd_word : '0;
            r_o_wpos    <= ptrf_pkg::W_POS'(r_wp);
        end
    end

    assign o_sts.sweep_last       = (r_sweep == LAST_ENTRY);
    assign o_sts.run_done         = run_done;
    assign o_sts.run_cnt_zero     = (r_run_cnt == '0);
    assign o_sts.high_left_zero   = (r_high_left == '0);
    assign o_sts.high_reload_zero = (r_high_reload == '0);
    assign o_sts.low_reload_zero  = (r_low_reload == '0);

    assign o_removed_entries = r_o_removed;
    assign o_entry_word      = r_o_word;
    assign o_write_position  = r_o_wpos;

endmodule

[src/pulse_train_ring_filler_unit.sv]
// Channel   Dir  Payload                                            Accepted when
// i_item    in   operation .. entry_index (six fields)              valid && ready
// o_result  out  removed_entries, entry_word, write_position        valid && ready
// i_cfg_*   in   pin_select / high_reload / low_reload by index     i_cfg_we
//
// One item at a time. Read: load, read, emit. Remove: load, calculate, apply, emit.
// Initialize: load, a fill pass over every ring entry, emit. Refill: one run at a
// constant level when a reload is zero, else alternating high and low runs; at most
// RING_DEPTH - 1 writes, one per cycle. After reset a clearing pass over every entry
// zeroes the ring; no item is taken meanwhile. A result waits in the output register
// while the next item is taken; it only holds off when a second result is ready first.
module pulse_train_ring_filler_unit #(
    parameter int RING_DEPTH = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ptrf_in_if.sink                           i_item,
    ptrf_out_if.source                        o_result,
    input  logic                              i_cfg_we,
    input  logic [ptrf_pkg::W_CFG_INDEX-1:0]  i_cfg_index,
    input  logic [ptrf_pkg::W_CFG_DATA-1:0]   i_cfg_data
);

    ptrf_pkg::t_dp_cmd dp_cmd;
    ptrf_pkg::t_dp_sts dp_sts;

    ptrf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_in_op     (i_item.operation),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    ptrf_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_sts             (dp_sts),
        .i_operation       (i_item.operation),
        .i_reader_position (i_item.reader_position),
        .i_fill_level      (i_item.fill_level),
        .i_remove_count    (i_item.remove_count),
        .i_keep_margin     (i_item.keep_margin),
        .i_entry_index     (i_item.entry_index),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_removed_entries (o_result.removed_entries),
        .o_entry_word      (o_result.entry_word),
        .o_write_position  (o_result.write_position)
    );

endmodule

[src/ptrf_checker.sv]
`include "assert_macros.svh"

module ptrf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [ptrf_pkg::W_POS-1:0]    i_out_removed,
    input logic [ptrf_pkg::W_WORD-1:0]   i_out_word,
    input logic [ptrf_pkg::W_POS-1:0]    i_out_wpos
);

    `PTRF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_wpos) && $stable(i_out_word) && $stable(i_out_removed))

    `PTRF_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    `PTRF_ASSERT_NEXT(a_no_instant_result, i_clk, i_rst_n, i_in_valid && i_in_ready, !$rose(i_out_valid))

    `PTRF_ASSERT_SAME(a_word_or_removed, i_clk, i_rst_n, i_out_valid && (i_out_removed != '0), i_out_word == '0)

endmodule

bind pulse_train_ring_filler_unit ptrf_checker u_ptrf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_item.valid),
    .i_in_ready    (i_item.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_out_removed (o_result.removed_entries),
    .i_out_word    (o_result.entry_word),
    .i_out_wpos    (o_result.write_position)
);

[bench/testbench.sv]
module testbench;

    localparam int RING_DEPTH    = 128;
    localparam int MAX_QUIET     = 6000;
    localparam int SETTLE_CYCLES = 600;
    localparam int SHOWN_ERRORS  = 10;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 125;

    typedef struct packed {
        logic [ptrf_pkg::W_OP-1:0]    op;
        logic [ptrf_pkg::W_POS-1:0]   reader;
        logic                         level;
        logic [ptrf_pkg::W_COUNT-1:0] count;
        logic [ptrf_pkg::W_POS-1:0]   margin;
        logic [ptrf_pkg::W_POS-1:0]   index;
        logic                         drain;
    } t_ring_cmd;

    typedef struct packed {
        logic [ptrf_pkg::W_POS-1:0]  removed;
        logic [ptrf_pkg::W_WORD-1:0] word;
        logic [ptrf_pkg::W_POS-1:0]  wpos;
    } t_ring_reply;

    logic                             i_clk     = 1'b0;
    logic                             i_rst_n   = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [ptrf_pkg::W_CFG_INDEX-1:0] cfg_index = '0;
    logic [ptrf_pkg::W_CFG_DATA-1:0]  cfg_data  = '0;
    logic                             item_valid = 1'b0;
    t_ring_cmd                        item_cur   = '0;
    logic                             res_ready  = 1'b0;

    ptrf_in_if  item_if();
    ptrf_out_if result_if();

    assign item_if.valid           = item_valid;
    assign item_if.operation       = item_cur.op;
    assign item_if.reader_position = item_cur.reader;
    assign item_if.fill_level      = item_cur.level;
    assign item_if.remove_count    = item_cur.count;
    assign item_if.keep_margin     = item_cur.margin;
    assign item_if.entry_index     = item_cur.index;
    assign result_if.ready         = res_ready;

    pulse_train_ring_filler_unit #(.RING_DEPTH(RING_DEPTH)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_if),
        .o_result    (result_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // predicted ring contents and filler state
    logic [ptrf_pkg::W_WORD-1:0] ring_model [RING_DEPTH];
    int unsigned wr_ptr;
    int unsigned high_left;
    int unsigned low_left;
    bit          resync;
    int unsigned pin_cfg;
    int unsigned high_cfg;
    int unsigned low_cfg;

    t_ring_cmd   pending_cmds[$];
    t_ring_reply expected_replies[$];

    int          in_flight    = 0;
    int          gap_left     = 0;
    int          stall_left   = 0;
    int          quiet_cycles = 0;
    int          failures     = 0;
    int          replies_seen = 0;
    int          settings_run = 1;
    int          op_seen [4]  = '{0, 0, 0, 0};
    int unsigned reader_at    = 0;
    bit          calm         = 1'b0;

    function automatic void paint_span(int unsigned start, int unsigned cnt, bit lvl);
        logic [ptrf_pkg::W_WORD-1:0] m;
        int unsigned k;
        m = '0;
        m[(pin_cfg + 1) % ptrf_pkg::PIN_COUNT] = 1'b1;
        for (int unsigned i = 0; i < cnt; i++) begin
            k = (start + i) % RING_DEPTH;
            if (lvl) begin
                ring_model[k] = (ring_model[k] | m) & ~(m << ptrf_pkg::W_HALF);
            end else begin
                ring_model[k] = (ring_model[k] | (m << ptrf_pkg::W_HALF)) & ~m;
            end
        end
    endfunction

    // writes up to cnt entries toward reader r, returns what is left of the run
    function automatic int unsigned lay_run(bit lvl, int unsigned cnt, int unsigned r);
        int unsigned p;
        int unsigned room;
        p = wr_ptr;
        if (resync) begin
            resync = 1'b0;
            p = (r + ptrf_pkg::RESYNC_LEAD) % RING_DEPTH;
        end
        if (r < p) begin
            room = RING_DEPTH - p;
            if (cnt > room) begin
                cnt -= room;
                paint_span(p, room, lvl);
                p = 0;
            end else begin
                paint_span(p, cnt, lvl);
                wr_ptr = (p + cnt) % RING_DEPTH;
                return 0;
            end
        end
        room = r - p;
        if (cnt > room) begin
            cnt -= room;
            paint_span(p, room, lvl);
            p = r;
        end else begin
            paint_span(p, cnt, lvl);
            p += cnt;
            cnt = 0;
        end
        wr_ptr = p % RING_DEPTH;
        return cnt;
    endfunction

    function automatic t_ring_reply ring_apply(t_ring_cmd c);
        t_ring_reply res;
        int unsigned r;
        int unsigned taken;
        int          queued;
        bit          again;
        res = '0;
        r = c.reader % RING_DEPTH;
        case (c.op)
            ptrf_pkg::OP_REFILL: begin
                if (high_cfg == 0) begin
                    void'(lay_run(1'b0, RING_DEPTH, r));
                end else if (low_cfg == 0) begin
                    void'(lay_run(1'b1, RING_DEPTH, r));
                end else begin
                    again = 1'b1;
                    while (again) begin
                        again = 1'b0;
                        if (high_left > 0) begin
                            high_left = lay_run(1'b1, high_left, r);
                            low_left = low_cfg;
                        end
                        if (high_left == 0) begin
                            low_left = lay_run(1'b0, low_left, r);
                            if (low_left == 0) begin
                                high_left = high_cfg;
                                low_left = low_cfg;
                                again = 1'b1;
                            end
                        end
                    end
                end
            end
            ptrf_pkg::OP_INIT: begin
                paint_span(0, RING_DEPTH, c.level);
                resync = 1'b1;
            end
            ptrf_pkg::OP_REMOVE: begin
                if (r != wr_ptr) begin
                    queued = (r > wr_ptr) ? int'(RING_DEPTH - r + wr_ptr) : int'(wr_ptr - r);
                    queued -= int'(c.margin);
                    if (queued > 0) begin
                        taken = (queued >= int'(c.count)) ? int'(c.count) : queued;
                        wr_ptr = (wr_ptr + RING_DEPTH - taken) % RING_DEPTH;
                        res.removed = ptrf_pkg::W_POS'(taken);
                    end
                end
            end
            default: res.word = ring_model[c.index % RING_DEPTH];
        endcase
        res.wpos = ptrf_pkg::W_POS'(wr_ptr);
        return res;
    endfunction

    initial begin : clock_gen
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin : driver
        bit took;
        bit gave;
        int open_now;
        took = item_valid && item_if.ready;
        gave = result_if.valid && res_ready;
        open_now = in_flight + int'(took) - int'(gave);
        if (!i_rst_n) begin
            item_valid <= 1'b0;
        end else begin
            if (took) begin
                expected_replies.push_back(ring_apply(item_cur));
                op_seen[item_cur.op]++;
            end
            in_flight <= open_now;
            if (!item_valid || item_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    item_valid <= 1'b0;
                end else if (pending_cmds.size() == 0 ||
                             (pending_cmds[0].drain && open_now != 0)) begin
                    item_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    gap_left = $urandom_range(0, 5);
                    item_valid <= 1'b0;
                end else begin
                    item_cur <= pending_cmds.pop_front();
                    item_valid <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_ring_reply got;
        t_ring_reply want;
        if (!i_rst_n) begin
            res_ready <= 1'b0;
        end else begin
            if (result_if.valid && res_ready) begin
                got = {result_if.removed_entries, result_if.entry_word,
                       result_if.write_position};
                replies_seen++;
                if (expected_replies.size() == 0) begin
                    failures++;
                    if (failures <= SHOWN_ERRORS)
                        $display("unexpected result: removed %0d word %h wpos %0d",
                                 got.removed, got.word, got.wpos);
                end else begin
                    want = expected_replies.pop_front();
                    if (got.removed !== want.removed || got.word !== want.word ||
                        got.wpos !== want.wpos) begin
                        failures++;
                        if (failures <= SHOWN_ERRORS) begin
                            $display("result %0d mismatch (exp/act): removed %0d/%0d",
                                     replies_seen, want.removed, got.removed);
                            $display("  word %h/%h wpos %0d/%0d",
                                     want.word, got.word, want.wpos, got.wpos);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                res_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 5);
                res_ready <= 1'b0;
            end else begin
                res_ready <= 1'b1;
            end
            if ((item_valid && item_if.ready) || (result_if.valid && res_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= MAX_QUIET) begin
                $display("watchdog: no handshake for %0d cycles", MAX_QUIET);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic queue_cmd(logic [ptrf_pkg::W_OP-1:0] op, int unsigned reader, bit level,
                             int unsigned count, int unsigned margin, int unsigned index,
                             bit drain);
        t_ring_cmd c;
        c.op     = op;
        c.reader = ptrf_pkg::W_POS'(reader);
        c.level  = level;
        c.count  = ptrf_pkg::W_COUNT'(count);
        c.margin = ptrf_pkg::W_POS'(margin);
        c.index  = ptrf_pkg::W_POS'(index);
        c.drain  = drain;
        pending_cmds.push_back(c);
    endtask

    task automatic queue_random(int n);
        t_ring_cmd   c;
        int unsigned sel;
        for (int i = 0; i < n; i++) begin
            c.op     = ptrf_pkg::OP_READ;
            c.reader = ptrf_pkg::W_POS'($urandom);
            c.level  = 1'($urandom);
            c.count  = ptrf_pkg::W_COUNT'($urandom);
            c.margin = ptrf_pkg::W_POS'($urandom);
            c.index  = ptrf_pkg::W_POS'($urandom);
            c.drain  = ($urandom_range(0, 49) == 0);
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                c.op = ptrf_pkg::OP_REFILL;
                // reader mostly moves forward like a real port engine
                if ($urandom_range(0, 6) != 0) begin
                    reader_at = (reader_at + $urandom_range(1, 40)) % RING_DEPTH;
                    c.reader = ptrf_pkg::W_POS'(reader_at);
                end
            end else if (sel < 70) begin
                c.op = ptrf_pkg::OP_READ;
            end else if (sel < 90) begin
                c.op = ptrf_pkg::OP_REMOVE;
                if ($urandom_range(0, 4) != 0)
                    c.reader = ptrf_pkg::W_POS'(reader_at);
                case ($urandom_range(0, 4))
                    0, 1, 2: c.count = ptrf_pkg::W_COUNT'($urandom_range(0, 20));
                    3:       c.count = ptrf_pkg::W_COUNT'($urandom_range(0, 127));
                    default: ;
                endcase
                if ($urandom_range(0, 1) == 0)
                    c.margin = ptrf_pkg::W_POS'($urandom_range(0, 15));
            end else begin
                c.op = ptrf_pkg::OP_INIT;
            end
            pending_cmds.push_back(c);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_cmds.size() != 0 || item_valid || in_flight != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_config(int unsigned pin, int unsigned hr, int unsigned lr);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= ptrf_pkg::CFG_PIN_SELECT;
        cfg_data  <= ptrf_pkg::W_CFG_DATA'(pin);
        @(posedge i_clk);
        cfg_index <= ptrf_pkg::CFG_HIGH_RELOAD;
        cfg_data  <= ptrf_pkg::W_CFG_DATA'(hr);
        @(posedge i_clk);
        cfg_index <= ptrf_pkg::CFG_LOW_RELOAD;
        cfg_data  <= ptrf_pkg::W_CFG_DATA'(lr);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        pin_cfg  = pin;
        high_cfg = hr;
        low_cfg  = lr;
        settings_run++;
        @(negedge i_clk);
    endtask

    function automatic int unsigned pick_reload();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 65535;
            2, 3, 4: return $urandom_range(1, 4);
            5, 6:    return $urandom_range(5, 40);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    initial begin : stimulus
        for (int i = 0; i < RING_DEPTH; i++)
            ring_model[i] = '0;
        wr_ptr    = 0;
        high_left = 0;
        low_left  = 0;
        resync    = 1'b0;
        pin_cfg   = 0;
        high_cfg  = 0;
        low_cfg   = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset registers: constant low on bit 1
        queue_cmd(ptrf_pkg::OP_READ,     0, 0,     0,   0,   0, 0);
        queue_cmd(ptrf_pkg::OP_REFILL,   0, 0,     0,   0,   0, 0);   // writer at reader, nothing written
        queue_cmd(ptrf_pkg::OP_REFILL, 127, 0,     0,   0,   0, 0);
        queue_cmd(ptrf_pkg::OP_READ,     0, 0,     0,   0, 126, 0);
        queue_cmd(ptrf_pkg::OP_READ,     0, 0,     0,   0, 127, 0);
        queue_cmd(ptrf_pkg::OP_REMOVE, 127, 0, 65535,   0,   0, 0);   // nothing queued
        queue_cmd(ptrf_pkg::OP_REMOVE,   0, 0, 65535,   0,   0, 0);   // retract all
        queue_cmd(ptrf_pkg::OP_REFILL, 100, 0,     0,   0,   0, 0);
        queue_cmd(ptrf_pkg::OP_REMOVE,  10, 0,     5, 127,   0, 0);   // margin covers queue
        queue_cmd(ptrf_pkg::OP_REMOVE,  10, 0,     0,   0,   0, 0);
        queue_cmd(ptrf_pkg::OP_INIT,     0, 1,     0,   0,   0, 1);   // drain first
        queue_cmd(ptrf_pkg::OP_READ,     0, 0,     0,   0,  64, 0);
        queue_cmd(ptrf_pkg::OP_REFILL, 120, 0,     0,   0,   0, 0);   // resync wraps
        wait_idle();

        set_config(7, 3, 2);
        queue_cmd(ptrf_pkg::OP_INIT,     0, 0,     0,   0,   0, 0);
        queue_cmd(ptrf_pkg::OP_REFILL,  40, 0,     0,   0,   0, 0);
        queue_cmd(ptrf_pkg::OP_READ,     0, 0,     0,   0,   0, 0);
        queue_cmd(ptrf_pkg::OP_REFILL,  40, 0,     0,   0,   0, 0);
        queue_cmd(ptrf_pkg::OP_REMOVE,  30, 0, 65535,   3,   0, 0);
        queue_cmd(ptrf_pkg::OP_REFILL,  35, 0,     0,   0,   0, 0);   // run resumes
        queue_cmd(ptrf_pkg::OP_READ,     0, 0,     0,   0,  34, 0);
        queue_cmd(ptrf_pkg::OP_READ,     0, 0,     0,   0, 127, 0);
        wait_idle();

        set_config(0, 65535, 0);
        queue_cmd(ptrf_pkg::OP_REFILL,  90, 0,     0,   0,   0, 0);
        queue_cmd(ptrf_pkg::OP_READ,     0, 0,     0,   0,  89, 0);
        wait_idle();

        set_config(5, 0, 65535);
        queue_cmd(ptrf_pkg::OP_REFILL,  10, 0,     0,   0,   0, 0);
        queue_cmd(ptrf_pkg::OP_READ,     0, 0,     0,   0,   9, 0);
        reader_at = 10;

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0:       set_config(7, 65535, 65535);
                1:       set_config(0, 1, 1);
                2:       set_config(7, 65535, 3);
                3:       set_config(0, 2, 65535);
                default: set_config($urandom_range(0, 7), pick_reload(), pick_reload());
            endcase
            calm = (ph == 5) || (ph == RANDOM_PHASES - 1);
            queue_random(PHASE_ITEMS);
        end
        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("%0d items (%0d refill, %0d initialize, %0d remove, %0d read) over %0d settings",
                 op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3],
                 op_seen[ptrf_pkg::OP_REFILL], op_seen[ptrf_pkg::OP_INIT],
                 op_seen[ptrf_pkg::OP_REMOVE], op_seen[ptrf_pkg::OP_READ], settings_run);
        $display("%0d results checked, %0d failures, %0d still expected",
                 replies_seen, failures, expected_replies.size());
        if (failures == 0 && expected_replies.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
